// File: rtl/apnh_pkg.sv
// apnh_pkg: shared constants, types and the hash step for the archive path-name hash
// used by apnh_front, apnh_queue, apnh_back and archive_path_name_hash
// no dependencies
package apnh_pkg;

   // longest name that still hashes reliably
   localparam int MaxLen = 1024;
   // character count saturates at MaxLen + 1
   localparam int CountWidth = $clog2(MaxLen + 2);

   // depth of the queue between front and back
   localparam int QueueDepth = 2;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   localparam logic [7:0] CharDot = 8'h2E;
   localparam logic [7:0] CharSlash = 8'h2F;
   localparam logic [7:0] CharBackslash = 8'h5C;
   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperZ = 8'h5A;
   localparam logic [7:0] CaseOffset = 8'h20;

   // packed extension text, dot first
   localparam logic [31:0] ExtTextNif = 32'h2E6E6966;
   localparam logic [31:0] ExtTextKf = 32'h002E6B66;
   localparam logic [31:0] ExtTextDds = 32'h2E646473;
   localparam logic [31:0] ExtTextWav = 32'h2E776176;

   typedef logic [2:0] ext_code_type;
   localparam ext_code_type ExtNone = 3'd0;
   localparam ext_code_type ExtNif = 3'd1;
   localparam ext_code_type ExtKf = 3'd2;
   localparam ext_code_type ExtDds = 3'd3;
   localparam ext_code_type ExtWav = 3'd4;

   // one finished name, handed from front to back
   typedef struct packed {
      logic too_long;
      logic has_ext;
      logic [CountWidth-1:0] stem_len;
      logic [7:0] stem_last;
      logic [7:0] stem_second;
      logic [7:0] stem_first;
      logic [31:0] stem_hash;
      logic [31:0] ext_hash;
      ext_code_type ext_code;
   } apnh_rec_type;

   // h * 0x1003f + c, mod 2^32, as shifts and adds
   function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] c);
      hash_step = (h << 16) + (h << 6) - h + {24'd0, c};
   endfunction

endpackage

// File: rtl/apnh_front.sv
// apnh_front: accepts path-name characters, normalizes them and keeps the running
// stem and extension state; emits one finished-name record per name
// depends on apnh_pkg
module apnh_front import apnh_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic [7:0] char_code,
   input  logic is_last,
   input  logic empty_name,
   output logic rec_push,
   output apnh_rec_type rec
);

   logic [CountWidth-1:0] count_ff, count_in, upd_count;
   logic [7:0] first_ff, first_in, upd_first;
   logic [7:0] prev_ff, prev_in;
   logic [7:0] bprev_ff, bprev_in;
   logic [31:0] dhash_ff, dhash_in, upd_dhash;
   logic dot_ff, dot_in, upd_dot;
   logic [CountWidth-1:0] snap_len_ff, snap_len_in, upd_snap_len;
   logic [7:0] snap_last_ff, snap_last_in, upd_snap_last;
   logic [7:0] snap_second_ff, snap_second_in, upd_snap_second;
   logic [7:0] snap_first_ff, snap_first_in, upd_snap_first;
   logic [31:0] snap_hash_ff, snap_hash_in, upd_snap_hash;
   logic [31:0] ext_hash_ff, ext_hash_in, upd_ext_hash;
   logic [31:0] ext_chars_ff, ext_chars_in, upd_ext_chars;
   logic [2:0] ext_len_ff, ext_len_in, upd_ext_len;
   logic overflow_ff, overflow_in, upd_overflow;
   logic [7:0] char_norm;
   logic finish;
   ext_code_type code;

   // lowercase and slash folding
   always_comb begin
      char_norm = char_code;
      if (char_code >= CharUpperA && char_code <= CharUpperZ) begin
         char_norm = char_code + CaseOffset;
      end else if (char_code == CharSlash) begin
         char_norm = CharBackslash;
      end
   end

   // state after this character
   always_comb begin
      upd_dot = dot_ff;
      upd_snap_len = snap_len_ff;
      upd_snap_last = snap_last_ff;
      upd_snap_second = snap_second_ff;
      upd_snap_first = snap_first_ff;
      upd_snap_hash = snap_hash_ff;
      upd_ext_hash = ext_hash_ff;
      upd_ext_chars = ext_chars_ff;
      upd_ext_len = ext_len_ff;
      if (char_norm == CharDot) begin
         upd_snap_len = count_ff;
         upd_snap_last = prev_ff;
         upd_snap_second = (count_ff > CountWidth'(2)) ? bprev_ff : 8'd0;
         upd_snap_first = first_ff;
         upd_snap_hash = dhash_ff;
         upd_dot = 1'b1;
         upd_ext_hash = {24'd0, char_norm};
         upd_ext_chars = {24'd0, char_norm};
         upd_ext_len = 3'd1;
      end else if (dot_ff) begin
         upd_ext_hash = hash_step(ext_hash_ff, char_norm);
         if (ext_len_ff < 3'd4) begin
            upd_ext_chars = {ext_chars_ff[23:0], char_norm};
         end
         if (ext_len_ff < 3'd5) begin
            upd_ext_len = ext_len_ff + 3'd1;
         end
      end
      upd_dhash = (count_ff >= CountWidth'(3)) ? hash_step(dhash_ff, bprev_ff) : dhash_ff;
      upd_first = (count_ff == '0) ? char_norm : first_ff;
      upd_count = (count_ff <= CountWidth'(MaxLen)) ? count_ff + CountWidth'(1) : count_ff;
      upd_overflow = overflow_ff | (upd_count > CountWidth'(MaxLen));
   end

   // extension classification
   always_comb begin
      code = ExtNone;
      if (upd_ext_len == 3'd4 && upd_ext_chars == ExtTextNif) code = ExtNif;
      if (upd_ext_len == 3'd3 && upd_ext_chars == ExtTextKf) code = ExtKf;
      if (upd_ext_len == 3'd4 && upd_ext_chars == ExtTextDds) code = ExtDds;
      if (upd_ext_len == 3'd4 && upd_ext_chars == ExtTextWav) code = ExtWav;
   end

   assign finish = accept && (is_last || empty_name);
   assign rec_push = finish;

   // finished-name record; an empty name gives the all-zero record
   always_comb begin
      rec = '0;
      if (!empty_name) begin
         rec.too_long = upd_overflow;
         rec.has_ext = upd_dot;
         rec.ext_hash = upd_ext_hash;
         rec.ext_code = code;
         if (upd_dot) begin
            rec.stem_len = upd_snap_len;
            rec.stem_last = upd_snap_last;
            rec.stem_second = upd_snap_second;
            rec.stem_first = upd_snap_first;
            rec.stem_hash = upd_snap_hash;
         end else begin
            rec.stem_len = upd_count;
            rec.stem_last = char_norm;
            rec.stem_second = (upd_count > CountWidth'(2)) ? prev_ff : 8'd0;
            rec.stem_first = upd_first;
            rec.stem_hash = upd_dhash;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      first_in = first_ff;
      prev_in = prev_ff;
      bprev_in = bprev_ff;
      dhash_in = dhash_ff;
      dot_in = dot_ff;
      snap_len_in = snap_len_ff;
      snap_last_in = snap_last_ff;
      snap_second_in = snap_second_ff;
      snap_first_in = snap_first_ff;
      snap_hash_in = snap_hash_ff;
      ext_hash_in = ext_hash_ff;
      ext_chars_in = ext_chars_ff;
      ext_len_in = ext_len_ff;
      overflow_in = overflow_ff;
      if (finish) begin
         count_in = '0;
         first_in = '0;
         prev_in = '0;
         bprev_in = '0;
         dhash_in = '0;
         dot_in = 1'b0;
         snap_len_in = '0;
         snap_last_in = '0;
         snap_second_in = '0;
         snap_first_in = '0;
         snap_hash_in = '0;
         ext_hash_in = '0;
         ext_chars_in = '0;
         ext_len_in = '0;
         overflow_in = 1'b0;
      end else if (accept) begin
         count_in = upd_count;
         first_in = upd_first;
         prev_in = char_norm;
         bprev_in = prev_ff;
         dhash_in = upd_dhash;
         dot_in = upd_dot;
         snap_len_in = upd_snap_len;
         snap_last_in = upd_snap_last;
         snap_second_in = upd_snap_second;
         snap_first_in = upd_snap_first;
         snap_hash_in = upd_snap_hash;
         ext_hash_in = upd_ext_hash;
         ext_chars_in = upd_ext_chars;
         ext_len_in = upd_ext_len;
         overflow_in = upd_overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         first_ff <= '0;
         prev_ff <= '0;
         bprev_ff <= '0;
         dhash_ff <= '0;
         dot_ff <= 1'b0;
         snap_len_ff <= '0;
         snap_last_ff <= '0;
         snap_second_ff <= '0;
         snap_first_ff <= '0;
         snap_hash_ff <= '0;
         ext_hash_ff <= '0;
         ext_chars_ff <= '0;
         ext_len_ff <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         first_ff <= first_in;
         prev_ff <= prev_in;
         bprev_ff <= bprev_in;
         dhash_ff <= dhash_in;
         dot_ff <= dot_in;
         snap_len_ff <= snap_len_in;
         snap_last_ff <= snap_last_in;
         snap_second_ff <= snap_second_in;
         snap_first_ff <= snap_first_in;
         snap_hash_ff <= snap_hash_in;
         ext_hash_ff <= ext_hash_in;
         ext_chars_ff <= ext_chars_in;
         ext_len_ff <= ext_len_in;
         overflow_ff <= overflow_in;
      end
   end

   // a finished name leaves no trace for the next one
   assert property (@(posedge clock) disable iff (reset)
      finish |=> (count_ff == '0 && !dot_ff && dhash_ff == '0 && !overflow_ff))
      else $error("front state not cleared after finished name");

   // the count saturates and the flag follows it
   assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CountWidth'(MaxLen + 1)) &&
      (overflow_ff == (count_ff > CountWidth'(MaxLen))))
      else $error("character count or overflow flag out of step");

endmodule

// File: rtl/apnh_queue.sv
// apnh_queue: short queue of finished-name records between front and back
// depends on apnh_pkg
module apnh_queue import apnh_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  apnh_rec_type push_rec,
   output logic full,
   input  logic pop,
   output logic empty,
   output apnh_rec_type pop_rec
);

   apnh_rec_type entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCountWidth-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == QueueCountWidth'(QueueDepth));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_rec = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0
                     : wr_ptr_ff + QueuePtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0
                     : rd_ptr_ff + QueuePtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QueueCountWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QueueCountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // front only pushes when there is room
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("record pushed into full queue");

   // occupancy matches the pointer distance
   assert property (@(posedge clock) disable iff (reset)
      (count_ff <= QueueCountWidth'(QueueDepth)) &&
      ((count_ff == '0 || count_ff == QueueCountWidth'(QueueDepth)) ==
       (wr_ptr_ff == rd_ptr_ff)))
      else $error("queue pointers and count disagree");

endmodule

// File: rtl/apnh_back.sv
// apnh_back: turns a finished-name record into the 64-bit name hash and holds it
// in the result register until popped
// depends on apnh_pkg
module apnh_back import apnh_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic q_empty,
   input  apnh_rec_type q_rec,
   output logic q_pop,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [63:0] rsp_name_hash,
   output logic rsp_too_long
);

   logic valid_ff, valid_in;
   logic [63:0] hash_ff, hash_in;
   logic too_long_ff, too_long_in;
   logic [63:0] h_stem, h_sum;
   logic [7:0] mix_b0, mix_b1, mix_b3;
   logic take;

   // stem bytes, then stem and extension hashes in the upper word
   always_comb begin
      h_stem = '0;
      if (q_rec.stem_len != '0) begin
         h_stem = {56'd0, q_rec.stem_last}
                + {48'd0, q_rec.stem_second, 8'd0}
                + (64'(q_rec.stem_len) << 16)
                + {32'd0, q_rec.stem_first, 24'd0};
         if (q_rec.stem_len > CountWidth'(3)) begin
            h_stem = h_stem + {q_rec.stem_hash, 32'd0};
         end
      end
      h_sum = q_rec.has_ext ? h_stem + {q_rec.ext_hash, 32'd0} : h_stem;
   end

   // known extensions fold their code into bytes 3, 1 and 0
   always_comb begin
      mix_b3 = h_sum[31:24] + {q_rec.ext_code[2], 7'd0};
      mix_b1 = h_sum[15:8] + {q_rec.ext_code[0], 7'd0};
      mix_b0 = h_sum[7:0] + {q_rec.ext_code[1], 7'd0};
      hash_in = h_sum;
      if (q_rec.has_ext && q_rec.ext_code != ExtNone) begin
         hash_in = {h_sum[63:32], mix_b3, h_sum[23:16], mix_b1, mix_b0};
      end
      too_long_in = q_rec.too_long;
   end

   assign take = !q_empty && (!valid_ff || rsp_pop);
   assign q_pop = take;
   assign valid_in = take || (valid_ff && !rsp_pop);

   always_ff @(posedge clock) begin
      if (take) begin
         hash_ff <= hash_in;
         too_long_ff <= too_long_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_name_hash = hash_ff;
   assign rsp_too_long = too_long_ff;

endmodule

// File: rtl/archive_path_name_hash.sv
// archive_path_name_hash: top level of the streaming archive path-name hash
// depends on apnh_pkg, apnh_front, apnh_queue and apnh_back
//
// one path-name character per request enters through a queue-style port (req_push,
// req_full) and one 64-bit archive name hash per finished name leaves through
// another (rsp_empty, rsp_pop). characters are lowercased, '/' becomes '\', and the
// name is split at its last dot; the low word carries the stem's last, second-last
// and first characters and its length, the high word the 0x1003f multiplicative
// hashes of the stem middle and of the extension, and .nif/.kf/.dds/.wav fold a code
// into the low bytes. req_empty_name ends an empty name and yields a zero hash.
// a name of more than MaxLen characters sets rsp_too_long. a character is taken
// every cycle that req_full is low: the front updates its running state with one
// shift-and-add step of each hash per character, so the rate is one request per
// cycle while req_full is low. a finished name is written into a two-entry record
// queue and its hash moves on into the result register once that is free; req_full
// rises only when two finished names wait behind a stalled result register.
module archive_path_name_hash import apnh_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic [7:0] req_char_code,
   input  logic req_is_last,
   input  logic req_empty_name,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [63:0] rsp_name_hash,
   output logic rsp_too_long
);

   logic accept;
   logic rec_push;
   apnh_rec_type rec;
   logic q_full, q_empty, q_pop;
   apnh_rec_type q_rec;

   // full is conservative: ordinary characters never need queue room
   assign req_full = q_full;
   assign accept = req_push && !q_full;

   // front: normalize, track stem and extension, build the record
   apnh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .char_code  (req_char_code),
      .is_last    (req_is_last),
      .empty_name (req_empty_name),
      .rec_push   (rec_push),
      .rec        (rec)
   );

   // records of finished names waiting for the back
   apnh_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rec_push),
      .push_rec (rec),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_rec  (q_rec)
   );

   // back: final combine and result register
   apnh_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_rec         (q_rec),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_name_hash (rsp_name_hash),
      .rsp_too_long  (rsp_too_long)
   );

endmodule
